/* src/pplh_pkg.sv */
// ----------------------------------------------------------------------------
// pplh_pkg
// Shared types, phase codes and constants for the parallel port link block.
// ----------------------------------------------------------------------------
package pplh_pkg;

  localparam int unsigned LONG_W  = 22;
  localparam int unsigned SHORT_W = 16;
  localparam int unsigned TRY_W   = 6;
  localparam int unsigned PHASE_W = 4;

  // command codes
  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_SYNC    = 3'd1;
  localparam logic [2:0] MODE_SEND    = 3'd2;
  localparam logic [2:0] MODE_RECEIVE = 3'd3;
  localparam logic [2:0] MODE_READY   = 3'd4;

  // register indexes
  localparam logic [1:0] REG_SEND_WAIT    = 2'd0;
  localparam logic [1:0] REG_RECEIVE_WAIT = 2'd1;
  localparam logic [1:0] REG_SYNC_WAIT    = 2'd2;
  localparam logic [1:0] REG_SYNC_TRIES   = 2'd3;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_SEND_LO = 4'd1;
  localparam logic [PHASE_W-1:0] PH_SEND_HI = 4'd2;
  localparam logic [PHASE_W-1:0] PH_RX_HI   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_RX_LO   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SYNC0   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_SYNC1   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_SYNC2   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_SYNC3   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_SYNC4   = 4'd9;
  localparam logic [PHASE_W-1:0] PH_CR_A    = 4'd10;
  localparam logic [PHASE_W-1:0] PH_CR_B    = 4'd11;

  // pin patterns
  localparam logic [7:0] DATA_SYNC_A = 8'hAA;
  localparam logic [7:0] DATA_SYNC_B = 8'h55;
  localparam logic [7:0] DATA_PARK   = 8'h80;
  localparam logic [7:0] DATA_ZERO   = 8'h00;
  localparam logic [3:0] CTRL_IDLE   = 4'd4;
  localparam logic [3:0] CTRL_STROBE = 4'd5;
  localparam logic [3:0] CTRL_SEL    = 4'd0;

  // register reset values
  localparam logic [LONG_W-1:0]  SEND_WAIT_RST    = 22'h300000;
  localparam logic [LONG_W-1:0]  RECEIVE_WAIT_RST = 22'h300000;
  localparam logic [SHORT_W-1:0] SYNC_WAIT_RST    = 16'd8192;
  localparam logic [TRY_W-1:0]   SYNC_TRIES_RST   = 6'd32;

  typedef struct packed {
    logic [LONG_W-1:0]  send_wait;
    logic [LONG_W-1:0]  receive_wait;
    logic [SHORT_W-1:0] sync_wait;
    logic [TRY_W-1:0]   sync_tries;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic [7:0] status_lines;
    logic [3:0] control_lines;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LONG_W-1:0]  wait_count;
    logic [TRY_W-1:0]   attempt_count;
    logic [7:0]         assembled_byte;
    logic [7:0]         held_tx_byte;
    logic               held_last;
    logic [7:0]         data_drive;
    logic [3:0]         control_drive;
  } state_t;

  typedef struct packed {
    logic [7:0] data_pins;
    logic [3:0] control_pins;
    logic       busy_res;
    logic       done_res;
    logic       error;
    logic [7:0] rx_byte;
  } res_t;

  localparam state_t STATE_RST = '{
    phase:          PH_IDLE,
    wait_count:     '0,
    attempt_count:  '0,
    assembled_byte: '0,
    held_tx_byte:   '0,
    held_last:      1'b0,
    data_drive:     DATA_PARK,
    control_drive:  CTRL_IDLE
  };

endpackage

/* src/parallel_port_link_handshake.sv */
// ----------------------------------------------------------------------------
// parallel_port_link_handshake
// Host side of a parallel port copier link, one sampling tick per transaction.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  in       | in_valid / in_stall       | mode tx_byte last_byte status_lines
//           |                           | control_lines
//  out      | out_valid / out_stall     | data_pins control_pins busy_res
//           |                           | done_res error rx_byte
//  cfg      | cfg_we                    | cfg_index cfg_data
//
//  one transaction per cycle sustained while the result is not stalled;
//  input register, then one pass of the step logic into the result register
//  a stalled result holds the step stage; in_stall rises only when both hold
//  rst clears the link state and loads the register defaults
// ----------------------------------------------------------------------------
module parallel_port_link_handshake import pplh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [LONG_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        mode,
  input  logic [7:0]        tx_byte,
  input  logic              last_byte,
  input  logic [7:0]        status_lines,
  input  logic [3:0]        control_lines,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        data_pins,
  output logic [3:0]        control_pins,
  output logic              busy_res,
  output logic              done_res,
  output logic              error,
  output logic [7:0]        rx_byte
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  item_t  item;
  res_t   res;
  res_t   res_q;
  logic   item_valid;
  logic   advance;
  logic   in_take;

  pplh_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pplh_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res)
  );

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= '{mode: mode, tx_byte: tx_byte, last_byte: last_byte,
                status_lines: status_lines, control_lines: control_lines};
    end
  end

  // link state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RST;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign data_pins    = res_q.data_pins;
  assign control_pins = res_q.control_pins;
  assign busy_res     = res_q.busy_res;
  assign done_res     = res_q.done_res;
  assign error        = res_q.error;
  assign rx_byte      = res_q.rx_byte;

endmodule

/* src/pplh_cfg.sv */
// ----------------------------------------------------------------------------
// pplh_cfg
// Wait limit and retry count registers behind the plain write port.
// ----------------------------------------------------------------------------
module pplh_cfg import pplh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [LONG_W-1:0] cfg_data,
  output cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.send_wait    <= SEND_WAIT_RST;
      cfg.receive_wait <= RECEIVE_WAIT_RST;
      cfg.sync_wait    <= SYNC_WAIT_RST;
      cfg.sync_tries   <= SYNC_TRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEND_WAIT:    cfg.send_wait    <= cfg_data;
        REG_RECEIVE_WAIT: cfg.receive_wait <= cfg_data;
        REG_SYNC_WAIT:    cfg.sync_wait    <= cfg_data[SHORT_W-1:0];
        REG_SYNC_TRIES:   cfg.sync_tries   <= cfg_data[TRY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* src/pplh_step.sv */
// ----------------------------------------------------------------------------
// pplh_step
// One sampling tick of the link: next phase, counters, pin drive and result.
// ----------------------------------------------------------------------------
module pplh_step import pplh_pkg::*; (
  input  cfg_t   cfg,
  input  state_t st,
  input  item_t  item,
  output state_t st_next,
  output res_t   res
);

  logic              busy_line;
  logic              sel_line;
  logic              want_sel;
  logic              done;
  logic              err;
  logic [7:0]        rx;
  logic [LONG_W-1:0] lim_raw;
  logic [LONG_W-1:0] lim_eff;
  logic [LONG_W-1:0] wait_inc;
  logic              wait_hit;
  logic [TRY_W-1:0]  tries_eff;
  logic [TRY_W-1:0]  attempt_inc;

  assign busy_line = item.status_lines[7];
  assign sel_line  = item.control_lines[3];

  // poll limit for the current phase
  always_comb begin
    case (st.phase)
      PH_SEND_LO, PH_SEND_HI: lim_raw = cfg.send_wait;
      PH_RX_HI, PH_RX_LO:     lim_raw = cfg.receive_wait;
      default:                lim_raw = {{(LONG_W-SHORT_W){1'b0}}, cfg.sync_wait};
    endcase
  end

  assign lim_eff     = (lim_raw == '0) ? LONG_W'(1) : lim_raw;
  assign wait_inc    = st.wait_count + LONG_W'(1);
  assign wait_hit    = (wait_inc >= lim_eff);
  assign tries_eff   = (cfg.sync_tries == '0) ? TRY_W'(1) : cfg.sync_tries;
  assign attempt_inc = st.attempt_count + TRY_W'(1);
  assign want_sel    = (st.phase == PH_SYNC1) || (st.phase == PH_SYNC3);

  always_comb begin
    st_next = st;
    done    = 1'b0;
    err     = 1'b0;
    rx      = '0;
    case (st.phase)
      PH_SEND_LO, PH_SEND_HI: begin
        if (item.control_lines[1] == (st.phase == PH_SEND_HI)) begin
          st_next.data_drive    = st.held_tx_byte;
          st_next.control_drive = (st.phase == PH_SEND_HI) ? CTRL_IDLE : CTRL_STROBE;
          done = 1'b1;
        end else begin
          st_next.wait_count = wait_inc;
          if (wait_hit) begin
            done = 1'b1;
            err  = 1'b1;
          end
        end
      end
      PH_RX_HI: begin
        if (busy_line) begin
          st_next.assembled_byte = {4'b0, item.status_lines[6:3]};
          st_next.data_drive     = DATA_ZERO;
          st_next.wait_count     = '0;
          st_next.phase          = PH_RX_LO;
        end else begin
          st_next.wait_count = wait_inc;
          if (wait_hit) begin
            done = 1'b1;
            err  = 1'b1;
          end
        end
      end
      PH_RX_LO: begin
        if (!busy_line) begin
          st_next.assembled_byte = st.assembled_byte | {item.status_lines[6:3], 4'b0};
          if (st.held_last) begin
            st_next.data_drive = DATA_PARK;
          end
          rx   = st_next.assembled_byte;
          done = 1'b1;
        end else begin
          st_next.wait_count = wait_inc;
          if (wait_hit) begin
            done = 1'b1;
            err  = 1'b1;
          end
        end
      end
      PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3, PH_SYNC4: begin
        if (sel_line == want_sel) begin
          case (st.phase)
            PH_SYNC0: begin
              st_next.data_drive    = DATA_SYNC_A;
              st_next.control_drive = CTRL_SEL;
            end
            PH_SYNC1: st_next.control_drive = CTRL_IDLE;
            PH_SYNC2: begin
              st_next.data_drive    = DATA_SYNC_B;
              st_next.control_drive = CTRL_SEL;
            end
            PH_SYNC3: st_next.control_drive = CTRL_IDLE;
            default:  done = 1'b1;
          endcase
          if (st.phase != PH_SYNC4) begin
            st_next.phase = st.phase + PHASE_W'(1);
          end
        end else begin
          st_next.wait_count = wait_inc;
          if (wait_hit) begin
            st_next.control_drive = CTRL_IDLE;
            st_next.attempt_count = attempt_inc;
            if (attempt_inc >= tries_eff) begin
              done = 1'b1;
              err  = 1'b1;
            end else begin
              st_next.data_drive = DATA_ZERO;
              st_next.wait_count = '0;
              st_next.phase      = PH_SYNC0;
            end
          end
        end
      end
      PH_CR_A: begin
        if (item.control_lines[1:0] == 2'b00 || item.control_lines[1:0] == 2'b11) begin
          st_next.data_drive = DATA_ZERO;
          st_next.wait_count = '0;
          st_next.phase      = PH_CR_B;
        end else begin
          st_next.wait_count = wait_inc;
          if (wait_hit) begin
            done = 1'b1;
            err  = 1'b1;
          end
        end
      end
      PH_CR_B: begin
        if (!busy_line) begin
          done = 1'b1;
        end else begin
          st_next.wait_count = wait_inc;
          if (wait_hit) begin
            done = 1'b1;
            err  = 1'b1;
          end
        end
      end
      default: begin
        st_next.phase      = PH_IDLE;
        st_next.wait_count = '0;
        case (item.mode)
          MODE_SYNC: begin
            st_next.attempt_count = '0;
            st_next.data_drive    = DATA_ZERO;
            st_next.control_drive = CTRL_IDLE;
            st_next.phase         = PH_SYNC0;
          end
          MODE_SEND: begin
            st_next.held_tx_byte = item.tx_byte;
            st_next.phase = item.control_lines[0] ? PH_SEND_HI : PH_SEND_LO;
          end
          MODE_RECEIVE: begin
            st_next.held_last      = item.last_byte;
            st_next.assembled_byte = '0;
            st_next.data_drive     = DATA_PARK;
            st_next.phase          = PH_RX_HI;
          end
          MODE_READY: st_next.phase = PH_CR_A;
          default: ;
        endcase
      end
    endcase
    if (done) begin
      st_next.phase = PH_IDLE;
    end
  end

  assign res.data_pins    = st_next.data_drive;
  assign res.control_pins = st_next.control_drive;
  assign res.busy_res     = (st_next.phase != PH_IDLE);
  assign res.done_res     = done;
  assign res.error        = err;
  assign res.rx_byte      = err ? 8'h00 : rx;

endmodule

/* src/pplh_checker.sv */
// ----------------------------------------------------------------------------
// pplh_checker
// Port level checks on the result channel of the link block.
// ----------------------------------------------------------------------------
module pplh_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  data_pins,
  input logic        busy_res,
  input logic        done_res,
  input logic        error,
  input logic [7:0]  rx_byte
);

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // stalled transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_pins) && $stable(rx_byte)
      && $stable(done_res))
    else $error("stalled result changed");

  // a finished command leaves the link idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done with busy still set");

  // error and received byte only with done, and never together
  a_err_rx: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error || rx_byte != 8'h00) |-> done_res && !(error && rx_byte != 8'h00))
    else $error("error or rx byte outside a finished command");

endmodule

bind parallel_port_link_handshake pplh_checker u_pplh_checker (.*);

/* tb/parallel_port_link_handshake_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parallel_port_link_handshake_tb
// Self-checking bench for the parallel port link: a short table of directed
// ticks, then random ticks shaped by the link's current phase, run under
// several register settings. A behavioral model of the link predicts the pin
// values and status of every tick, and each output transaction is compared
// with the oldest prediction. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module parallel_port_link_handshake_tb;
  import pplh_pkg::*;

  localparam int         QUIET_LIMIT = 2000;
  localparam int         HOLD_LEN    = 120;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  typedef struct packed {
    logic  is_cfg;
    cfg_t  cfg;
    item_t it;
    logic  typed;
    res_t  want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [LONG_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        mode;
  logic [7:0]        tx_byte;
  logic              last_byte;
  logic [7:0]        status_lines;
  logic [3:0]        control_lines;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        data_pins;
  logic [3:0]        control_pins;
  logic              busy_res;
  logic              done_res;
  logic              error;
  logic [7:0]        rx_byte;

  // link model state and registers
  cfg_t               link_cfg;
  logic [PHASE_W-1:0] lk_phase;
  logic [LONG_W-1:0]  lk_wait;
  logic [TRY_W-1:0]   lk_tries;
  logic [7:0]         lk_asm;
  logic [7:0]         lk_tx;
  logic               lk_last;
  logic [7:0]         lk_data;
  logic [3:0]         lk_ctrl;

  res_t link_outcomes[$];
  row_t dir_rows[$];
  int   mismatches = 0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;

  always #10 clk = ~clk;

  parallel_port_link_handshake i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .tx_byte      (tx_byte),
    .last_byte    (last_byte),
    .status_lines (status_lines),
    .control_lines(control_lines),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_pins    (data_pins),
    .control_pins (control_pins),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .error        (error),
    .rx_byte      (rx_byte)
  );

  function automatic bit miss_expired(logic [LONG_W-1:0] limit);
    lk_wait = lk_wait + LONG_W'(1);
    return lk_wait >= ((limit == '0) ? LONG_W'(1) : limit);
  endfunction

  function automatic void restart_sync();
    lk_data  = DATA_ZERO;
    lk_ctrl  = CTRL_IDLE;
    lk_wait  = '0;
    lk_phase = PH_SYNC0;
  endfunction

  function automatic res_t advance_link(item_t it);
    res_t             r;
    bit               fin;
    bit               bad;
    bit               want;
    logic [7:0]       got;
    logic [TRY_W-1:0] tries;
    fin = 1'b0;
    bad = 1'b0;
    got = '0;
    case (lk_phase)
      PH_SEND_LO, PH_SEND_HI: begin
        want = (lk_phase == PH_SEND_HI);
        if (it.control_lines[1] == want) begin
          lk_data = lk_tx;
          lk_ctrl = want ? CTRL_IDLE : CTRL_STROBE;
          fin = 1'b1;
        end else if (miss_expired(link_cfg.send_wait)) begin
          fin = 1'b1;
          bad = 1'b1;
        end
      end
      PH_RX_HI: begin
        if (it.status_lines[7]) begin
          lk_asm   = {4'h0, it.status_lines[6:3]};
          lk_data  = DATA_ZERO;
          lk_wait  = '0;
          lk_phase = PH_RX_LO;
        end else if (miss_expired(link_cfg.receive_wait)) begin
          fin = 1'b1;
          bad = 1'b1;
        end
      end
      PH_RX_LO: begin
        if (!it.status_lines[7]) begin
          lk_asm = lk_asm | {it.status_lines[6:3], 4'h0};
          if (lk_last) lk_data = DATA_PARK;
          got = lk_asm;
          fin = 1'b1;
        end else if (miss_expired(link_cfg.receive_wait)) begin
          fin = 1'b1;
          bad = 1'b1;
        end
      end
      PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3, PH_SYNC4: begin
        want = (lk_phase == PH_SYNC1) || (lk_phase == PH_SYNC3);
        if (it.control_lines[3] == want) begin
          case (lk_phase)
            PH_SYNC0: begin
              lk_data = DATA_SYNC_A;
              lk_ctrl = CTRL_SEL;
            end
            PH_SYNC2: begin
              lk_data = DATA_SYNC_B;
              lk_ctrl = CTRL_SEL;
            end
            PH_SYNC4: fin = 1'b1;
            default: lk_ctrl = CTRL_IDLE;
          endcase
          if (!fin) lk_phase = lk_phase + PHASE_W'(1);
        end else if (miss_expired(link_cfg.sync_wait)) begin
          tries    = (link_cfg.sync_tries == '0) ? TRY_W'(1) : link_cfg.sync_tries;
          lk_ctrl  = CTRL_IDLE;
          lk_tries = lk_tries + TRY_W'(1);
          if (lk_tries >= tries) begin
            fin = 1'b1;
            bad = 1'b1;
          end else begin
            restart_sync();
          end
        end
      end
      PH_CR_A: begin
        if (it.control_lines[1] == it.control_lines[0]) begin
          lk_data  = DATA_ZERO;
          lk_wait  = '0;
          lk_phase = PH_CR_B;
        end else if (miss_expired(link_cfg.sync_wait)) begin
          fin = 1'b1;
          bad = 1'b1;
        end
      end
      PH_CR_B: begin
        if (!it.status_lines[7]) begin
          fin = 1'b1;
        end else if (miss_expired(link_cfg.sync_wait)) begin
          fin = 1'b1;
          bad = 1'b1;
        end
      end
      default: begin
        lk_phase = PH_IDLE;
        lk_wait  = '0;
        case (it.mode)
          MODE_SYNC: begin
            lk_tries = '0;
            restart_sync();
          end
          MODE_SEND: begin
            lk_tx    = it.tx_byte;
            lk_phase = it.control_lines[0] ? PH_SEND_HI : PH_SEND_LO;
          end
          MODE_RECEIVE: begin
            lk_last  = it.last_byte;
            lk_asm   = '0;
            lk_data  = DATA_PARK;
            lk_phase = PH_RX_HI;
          end
          MODE_READY: lk_phase = PH_CR_A;
          default: ;
        endcase
      end
    endcase
    if (fin) lk_phase = PH_IDLE;
    r.data_pins    = lk_data;
    r.control_pins = lk_ctrl;
    r.busy_res     = (lk_phase != PH_IDLE);
    r.done_res     = fin;
    r.error        = bad;
    r.rx_byte      = bad ? 8'h00 : got;
    return r;
  endfunction

  // random tick whose lines answer the current wait with the given odds
  function automatic item_t shape_tick(int hit_pct);
    item_t it;
    bit    meet;
    it.mode          = 3'($urandom_range(0, 7));
    it.tx_byte       = 8'($urandom_range(0, 255));
    it.last_byte     = 1'($urandom_range(0, 1));
    it.status_lines  = 8'($urandom_range(0, 255));
    it.control_lines = 4'($urandom_range(0, 15));
    meet = ($urandom_range(0, 99) < hit_pct);
    case (lk_phase)
      PH_IDLE: begin
        if ($urandom_range(0, 9) < 8) it.mode = 3'($urandom_range(MODE_SYNC, MODE_READY));
      end
      PH_SEND_LO, PH_SEND_HI: it.control_lines[1] = meet ~^ (lk_phase == PH_SEND_HI);
      PH_RX_HI: it.status_lines[7] = meet;
      PH_RX_LO, PH_CR_B: it.status_lines[7] = !meet;
      PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3, PH_SYNC4:
        it.control_lines[3] = meet ~^ ((lk_phase == PH_SYNC1) || (lk_phase == PH_SYNC3));
      PH_CR_A: it.control_lines[1] = meet ~^ it.control_lines[0];
      default: ;
    endcase
    return it;
  endfunction

  function automatic void add_step(logic [2:0] m, logic [7:0] tx, logic lb, logic [7:0] st,
                                   logic [3:0] ctl, logic typed, res_t want);
    row_t r;
    r        = '0;
    r.it     = '{m, tx, lb, st, ctl};
    r.typed  = typed;
    r.want   = want;
    dir_rows.push_back(r);
  endfunction

  task automatic offer_tick(item_t it, logic typed, res_t want);
    res_t p;
    p = advance_link(it);
    link_outcomes.push_back(typed ? want : p);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= it.mode;
    tx_byte       <= it.tx_byte;
    last_byte     <= it.last_byte;
    status_lines  <= it.status_lines;
    control_lines <= it.control_lines;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic load_link_cfg(cfg_t c);
    in_valid <= 1'b0;
    while (link_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SEND_WAIT;
    cfg_data  <= c.send_wait;
    @(posedge clk);
    cfg_index <= REG_RECEIVE_WAIT;
    cfg_data  <= c.receive_wait;
    @(posedge clk);
    cfg_index <= REG_SYNC_WAIT;
    cfg_data  <= LONG_W'(c.sync_wait);
    @(posedge clk);
    cfg_index <= REG_SYNC_TRIES;
    cfg_data  <= LONG_W'(c.sync_tries);
    @(posedge clk);
    cfg_we   <= 1'b0;
    link_cfg = c;
  endtask

  task automatic run_phase(cfg_t c, int hit_pct, int n_ticks);
    load_link_cfg(c);
    repeat (n_ticks) offer_tick(shape_tick(hit_pct), 1'b0, '0);
  endtask

  // output checker
  always @(posedge clk) begin
    res_t w;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (link_outcomes.size() == 0) begin
        $error("output transaction with nothing expected");
        mismatches++;
      end else begin
        w = link_outcomes.pop_front();
        if (data_pins !== w.data_pins) begin
          $error("data_pins: expected %h, got %h", w.data_pins, data_pins);
          mismatches++;
        end
        if (control_pins !== w.control_pins) begin
          $error("control_pins: expected %h, got %h", w.control_pins, control_pins);
          mismatches++;
        end
        if (busy_res !== w.busy_res) begin
          $error("busy_res: expected %b, got %b", w.busy_res, busy_res);
          mismatches++;
        end
        if (done_res !== w.done_res) begin
          $error("done_res: expected %b, got %b", w.done_res, done_res);
          mismatches++;
        end
        if (error !== w.error) begin
          $error("error: expected %b, got %b", w.error, error);
          mismatches++;
        end
        if (rx_byte !== w.rx_byte) begin
          $error("rx_byte: expected %h, got %h", w.rx_byte, rx_byte);
          mismatches++;
        end
      end
    end
  end

  // result side stall bursts and the long hold
  initial begin
    int run;
    run = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        run = HOLD_LEN;
      end
      if (run > 0) begin
        run--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        run = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("parallel_port_link_handshake regression: fail");
    $finish;
  end

  initial begin
    cfg_t mid;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SEND_WAIT;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    mode          <= MODE_NONE;
    tx_byte       <= '0;
    last_byte     <= 1'b0;
    status_lines  <= '0;
    control_lines <= '0;

    link_cfg = '{SEND_WAIT_RST, RECEIVE_WAIT_RST, SYNC_WAIT_RST, SYNC_TRIES_RST};
    lk_phase = PH_IDLE;
    lk_wait  = '0;
    lk_tries = '0;
    lk_asm   = '0;
    lk_tx    = '0;
    lk_last  = 1'b0;
    lk_data  = DATA_PARK;
    lk_ctrl  = CTRL_IDLE;

    // idle ticks and unknown mode
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h0, 1'b1,
             '{DATA_PARK, CTRL_IDLE, 1'b0, 1'b0, 1'b0, 8'h00});
    add_step(MODE_UNUSED, 8'hFF, 1'b1, 8'hFF, 4'hF, 1'b1,
             '{DATA_PARK, CTRL_IDLE, 1'b0, 1'b0, 1'b0, 8'h00});
    // send with strobe low, mode ignored while busy
    add_step(MODE_SEND, 8'hFF, 1'b0, 8'h00, 4'h0, 1'b1,
             '{DATA_PARK, CTRL_IDLE, 1'b1, 1'b0, 1'b0, 8'h00});
    add_step(MODE_RECEIVE, 8'h00, 1'b1, 8'h00, 4'h2, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h0, 1'b0, '0);
    // send with strobe high
    add_step(MODE_SEND, 8'h00, 1'b0, 8'hFF, 4'h1, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h3, 1'b0, '0);
    // receive, last byte
    add_step(MODE_RECEIVE, 8'h00, 1'b1, 8'h00, 4'h0, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h0, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'hFF, 4'h0, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h78, 4'h0, 1'b0, '0);
    // receive, not last
    add_step(MODE_RECEIVE, 8'h00, 1'b0, 8'h00, 4'h0, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h80, 4'h0, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h0, 1'b0, '0);
    // ready check
    add_step(MODE_READY, 8'h00, 1'b0, 8'hFF, 4'h1, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'hFF, 4'h3, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h7F, 4'h0, 1'b0, '0);
    // full sync dance
    add_step(MODE_SYNC, 8'h00, 1'b0, 8'h00, 4'h0, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h0, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h8, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h0, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h8, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h0, 1'b0, '0);
    // zero limits act as one
    dir_rows.push_back('{1'b1, '{22'd0, 22'd0, 16'd0, 6'd0}, '0, 1'b0, '0});
    add_step(MODE_SEND, 8'hA5, 1'b0, 8'h00, 4'h0, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h2, 1'b0, '0);
    add_step(MODE_RECEIVE, 8'h00, 1'b1, 8'h00, 4'h0, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h0, 1'b0, '0);
    add_step(MODE_SYNC, 8'h00, 1'b0, 8'h00, 4'h0, 1'b0, '0);
    add_step(MODE_NONE, 8'h00, 1'b0, 8'h00, 4'h8, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg)
        load_link_cfg(dir_rows[k].cfg);
      else
        offer_tick(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);
    end

    run_phase('{22'h3FFFFF, 22'h3FFFFF, 16'hFFFF, 6'd63}, 60, 200);
    // long receiver hold while ticks keep coming
    load_link_cfg('{22'd1, 22'd3, 16'd2, 6'd1});
    hold_req = 1'b1;
    repeat (200) offer_tick(shape_tick(35), 1'b0, '0);
    mid.send_wait    = LONG_W'($urandom_range(1, 24));
    mid.receive_wait = LONG_W'($urandom_range(1, 24));
    mid.sync_wait    = SHORT_W'($urandom_range(1, 24));
    mid.sync_tries   = TRY_W'($urandom_range(1, 8));
    run_phase(mid, 45, 200);
    run_phase('{22'd2, 22'd1, 16'd1, 6'd63}, 50, 200);
    calm = 1'b1;
    run_phase('{SEND_WAIT_RST, RECEIVE_WAIT_RST, SYNC_WAIT_RST, SYNC_TRIES_RST}, 65, 200);

    in_valid <= 1'b0;
    while (link_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("parallel_port_link_handshake regression: pass");
    else
      $display("parallel_port_link_handshake regression: fail");
    $finish;
  end

endmodule

/* parallel_port_link_handshake.f */
src/pplh_pkg.sv
src/pplh_cfg.sv
src/pplh_step.sv
src/parallel_port_link_handshake.sv
src/pplh_checker.sv
tb/parallel_port_link_handshake_tb.sv
